// ===== hdl/blhm_pkg.sv =====
// Shared constants, types and config register codes for the battery low monitor.
`timescale 1ns / 1ps
package blhm_pkg;

  // Sample averaging and converter resolution
  localparam int NUM_SAMPLES = 8;
  localparam int ADC_BITS    = 12;

  // Fixed field widths of the streams
  localparam int IN_SAMPLES  = 8;
  localparam int SAMPLE_W    = 12;
  localparam int TIME_W      = 63;
  localparam int DUE_W       = 64;
  localparam int MV_W        = 13;
  localparam int THR_W       = 13;
  localparam int INTERVAL_W  = 32;
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  // Pipeline depth ahead of the output stage
  localparam int PIPE_DEPTH  = 5;

  // Scaling constants
  localparam int FULL_SCALE    = (1 << ADC_BITS) - 1;
  localparam int PIN_FULL_MV   = 2500;
  localparam int MULT_W        = 12;
  localparam int PIN_W         = 12;
  localparam int DIVIDER_RATIO = 2;

  // Sum of the lanes and its exact reciprocal divide by the sample count
  localparam int    SUM_W    = ADC_BITS + $clog2(NUM_SAMPLES);
  localparam int    AVG_K    = SUM_W + 3;
  localparam int    AVG_M_W  = AVG_K + 1;
  localparam longint AVG_M   = ((longint'(1) << AVG_K) + NUM_SAMPLES - 1) / NUM_SAMPLES;

  // Product avg * 2500 and its exact reciprocal divide by full scale
  localparam int    P_W      = ADC_BITS + MULT_W;
  localparam int    REC_K    = P_W + ADC_BITS;
  localparam int    REC_M_W  = P_W + 1;
  localparam longint REC_M   = ((longint'(1) << REC_K) + FULL_SCALE - 1) / FULL_SCALE;

  // Register reset values
  localparam int LOW_THR_RST   = 3300;
  localparam int RECOV_THR_RST = 3500;
  localparam int INTERVAL_RST  = 1000000;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THR   = 8'd0,
    REG_RECOV_THR = 8'd1,
    REG_INTERVAL  = 8'd2,
    REG_ENABLE    = 8'd3
  } blhm_cfg_reg_t;

  // Live configuration
  typedef struct packed {
    logic [THR_W-1:0]      low_thr;
    logic [THR_W-1:0]      recov_thr;
    logic [INTERVAL_W-1:0] interval;
    logic                  enable;
  } blhm_cfg_t;

  // Load enables of the arithmetic stages
  typedef struct packed {
    logic sum_en;
    logic avg_en;
    logic prod_en;
    logic mv_en;
  } blhm_stage_en_t;

endpackage

// ===== hdl/battery_low_hysteresis_monitor_unit.sv =====
// Top level of the battery low monitor: stream ports, config registers, lanes and pipeline.
`timescale 1ns / 1ps
// Takes one query beat per clock while the result side does not stall, and returns one
// result beat per query, in order. A query passes the lane, sum, average, product and
// millivolt registers and then the result register. The rate is set by the output stage,
// where the 64-bit due-time compare and add and the hysteresis flag close on themselves;
// the sample lanes, the adder tree and the two reciprocal multiplies ahead of it are
// pipelined. Every pipeline stage holds a beat and moves up into a free slot, so new
// queries keep coming in while a result waits, until every stage holds a beat.
// Config writes are always ready and should be made only while no query is in flight.
module battery_low_hysteresis_monitor_unit
  import blhm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // query stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, low bit up: now_time[62:0], sample_0 .. sample_7 (12 bits each), 1 pad bit
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, low bit up: battery_low, battery_mv[12:0], 2 pad bits
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: measured
  output logic                   out_tuser,
  // config write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  blhm_cfg_t               cfg_r;
  logic [PIPE_DEPTH:1]     vld_r;
  logic [PIPE_DEPTH+1:1]   en;
  logic                    out_valid_r;
  logic [TIME_W-1:0]       now_r [1:PIPE_DEPTH];
  logic [ADC_BITS-1:0]     lane_val [NUM_SAMPLES];
  logic [MV_W-1:0]         mv;
  blhm_stage_en_t          stage_en;
  logic                    battery_low;
  logic                    measured;
  logic [MV_W-1:0]         battery_mv;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr   <= THR_W'(LOW_THR_RST);
      cfg_r.recov_thr <= THR_W'(RECOV_THR_RST);
      cfg_r.interval  <= INTERVAL_W'(INTERVAL_RST);
      cfg_r.enable    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOW_THR:   cfg_r.low_thr   <= cfg_data[THR_W-1:0];
        REG_RECOV_THR: cfg_r.recov_thr <= cfg_data[THR_W-1:0];
        REG_INTERVAL:  cfg_r.interval  <= cfg_data[INTERVAL_W-1:0];
        REG_ENABLE:    cfg_r.enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the one after it advances
  always_comb begin
    en[PIPE_DEPTH+1] = !out_valid_r || out_tready;
    for (int k = PIPE_DEPTH; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (en[PIPE_DEPTH+1]) begin
        out_valid_r <= vld_r[PIPE_DEPTH];
      end
    end
  end

  // Carry the query time alongside the arithmetic
  always_ff @(posedge clk) begin
    if (en[1]) begin
      now_r[1] <= in_tdata[TIME_W-1:0];
    end
    for (int k = 2; k <= PIPE_DEPTH; k++) begin
      if (en[k]) begin
        now_r[k] <= now_r[k-1];
      end
    end
  end

  // Sample lanes
  for (genvar i = 0; i < NUM_SAMPLES; i++) begin : g_lane
    blhm_lane u_lane (
      .clk    (clk),
      .en     (en[1]),
      .sample (in_tdata[TIME_W + i*SAMPLE_W +: SAMPLE_W]),
      .lane_r (lane_val[i])
    );
  end

  assign stage_en.sum_en  = en[2];
  assign stage_en.avg_en  = en[3];
  assign stage_en.prod_en = en[4];
  assign stage_en.mv_en   = en[5];

  blhm_merge u_merge (
    .clk      (clk),
    .stage_en (stage_en),
    .lane_val (lane_val),
    .mv_r     (mv)
  );

  blhm_hyst u_hyst (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en[PIPE_DEPTH+1]),
    .vld           (vld_r[PIPE_DEPTH]),
    .cfg           (cfg_r),
    .now_time      (now_r[PIPE_DEPTH]),
    .mv            (mv),
    .battery_low_r (battery_low),
    .measured_r    (measured),
    .battery_mv_r  (battery_mv)
  );

  // Result beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-MV_W-1){1'b0}}, battery_mv, battery_low};
  assign out_tuser  = measured;

endmodule

// ===== hdl/blhm_lane.sv =====
// One sample lane: mask the raw count to converter resolution and register it.
`timescale 1ns / 1ps
module blhm_lane
  import blhm_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [ADC_BITS-1:0] lane_r
);

  logic [ADC_BITS-1:0] lane_nxt;

  // Drop bits above the converter width
  assign lane_nxt = ADC_BITS'(sample & SAMPLE_W'(FULL_SCALE));

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

// ===== hdl/blhm_merge.sv =====
// Merge the lanes: sum, floor average, scale to pin millivolts and double.
`timescale 1ns / 1ps
module blhm_merge
  import blhm_pkg::*;
(
  input  logic                clk,
  input  blhm_stage_en_t      stage_en,
  input  logic [ADC_BITS-1:0] lane_val [NUM_SAMPLES],
  output logic [MV_W-1:0]     mv_r
);

  logic [SUM_W-1:0]           sum_nxt;
  logic [SUM_W-1:0]           sum_r;
  logic [SUM_W+AVG_M_W-1:0]   avg_prod;
  logic [ADC_BITS-1:0]        avg_r;
  logic [P_W-1:0]             prod_nxt;
  logic [P_W-1:0]             prod_r;
  logic [P_W+REC_M_W-1:0]     rec_prod;
  logic [PIN_W-1:0]           pin;
  logic [MV_W-1:0]            mv_nxt;

  // Add up all lanes
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      sum_nxt = sum_nxt + SUM_W'(lane_val[i]);
    end
  end

  // Floor average by reciprocal multiply, exact over the sum range
  assign avg_prod = sum_r * AVG_M_W'(AVG_M);

  // Scale the average by the full pin voltage
  assign prod_nxt = avg_r * MULT_W'(PIN_FULL_MV);

  // Floor divide by full scale, then double for the divider
  assign rec_prod = prod_r * REC_M_W'(REC_M);
  assign pin      = rec_prod[REC_K +: PIN_W];
  assign mv_nxt   = MV_W'(pin * DIVIDER_RATIO);

  always_ff @(posedge clk) begin
    if (stage_en.sum_en) begin
      sum_r <= sum_nxt;
    end
    if (stage_en.avg_en) begin
      avg_r <= avg_prod[AVG_K +: ADC_BITS];
    end
    if (stage_en.prod_en) begin
      prod_r <= prod_nxt;
    end
    if (stage_en.mv_en) begin
      mv_r <= mv_nxt;
    end
  end

endmodule

// ===== hdl/blhm_hyst.sv =====
// Output stage: due-time check, hysteresis flag and the result register.
`timescale 1ns / 1ps
module blhm_hyst
  import blhm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld,
  input  blhm_cfg_t         cfg,
  input  logic [TIME_W-1:0] now_time,
  input  logic [MV_W-1:0]   mv,
  output logic              battery_low_r,
  output logic              measured_r,
  output logic [MV_W-1:0]   battery_mv_r
);

  logic              low_flag_r;
  logic              low_flag_nxt;
  logic [DUE_W-1:0]  next_due_r;
  logic [DUE_W-1:0]  next_due_nxt;
  logic [DUE_W-1:0]  now_ext;
  logic [MV_W-1:0]   mv_eff;
  logic              due;
  logic              low_nxt;

  assign now_ext = {1'b0, now_time};
  assign due     = now_ext >= next_due_r;
  assign mv_eff  = cfg.enable ? mv : '0;

  // Decide the flag and the next due time
  always_comb begin
    low_flag_nxt = low_flag_r;
    next_due_nxt = next_due_r;
    low_nxt      = low_flag_r;
    if (due) begin
      next_due_nxt = now_ext + DUE_W'(cfg.interval);
      if (mv_eff == '0) begin
        low_nxt = 1'b0;
      end else begin
        if (low_flag_r) begin
          low_flag_nxt = !(mv_eff >= cfg.recov_thr);
        end else begin
          low_flag_nxt = mv_eff < cfg.low_thr;
        end
        low_nxt = low_flag_nxt;
      end
    end
  end

  // Hold state across items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_flag_r <= 1'b0;
      next_due_r <= '0;
    end else if (en && vld) begin
      low_flag_r <= low_flag_nxt;
      next_due_r <= next_due_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (en && vld) begin
      battery_low_r <= low_nxt;
      measured_r    <= due;
      battery_mv_r  <= due ? mv_eff : '0;
    end
  end

endmodule

// ===== hdl/blhm_checker.sv =====
// Port-level checks for the battery low monitor, bound to the top level.
`timescale 1ns / 1ps
module blhm_checker
  import blhm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A result beat that took no measurement reports zero millivolts
  a_idle_mv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[MV_W:1] == '0))
    else $error("unmeasured result carries nonzero millivolts");

  // A zero reading never reports a low battery
  a_zero_not_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && (out_tdata[MV_W:1] == '0)) |-> !out_tdata[0])
    else $error("zero millivolt reading flagged low");

  // Input backs up only behind a stalled result
  a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser) && out_tvalid))
    else $error("stalled result changed");

endmodule

bind battery_low_hysteresis_monitor_unit blhm_checker u_blhm_checker (.*);
